// ===== rtl/core/dilp_pkg.sv =====
// Shared types and constants of the decimal line parser.
`default_nettype none

package dilp_pkg;

  localparam int VALUE_WIDTH_DEF = 32;
  localparam int CFG_INDEX_WIDTH = 2;

  // Character codes
  localparam logic [7:0] CHAR_NL    = 8'd10;
  localparam logic [7:0] CHAR_TAB   = 8'd9;
  localparam logic [7:0] CHAR_SPACE = 8'd32;
  localparam logic [7:0] CHAR_PLUS  = 8'd43;
  localparam logic [7:0] CHAR_MINUS = 8'd45;
  localparam logic [7:0] CHAR_0     = 8'd48;
  localparam logic [7:0] CHAR_9     = 8'd57;

  // Configuration register indexes
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_DEFAULT = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_MIN     = 2'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_MAX     = 2'd2;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_BAD   = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    PH_BLANK   = 2'd0,
    PH_DIGITS  = 2'd1,
    PH_DISCARD = 2'd2
  } phase_t;

  typedef struct packed {
    phase_t phase;
    logic   negative;
  } line_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/core/dilp_if.sv =====
// Character and result channel interfaces of the decimal line parser.
`default_nettype none

interface dilp_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink   (input valid, input char_code, output ready);
endinterface

interface dilp_out_if
  import dilp_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] value;
  status_t                       status;

  modport source (output valid, output value, output status, input ready);
  modport sink   (input valid, input value, input status, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/dilp_line_state.sv =====
// Per-line parse state: blank skipping, sign capture and saturating digit accumulation.
`default_nettype none

module dilp_line_state
  import dilp_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 step,
  input  wire logic [7:0]           char_code,
  output line_ctrl_t                ctrl,
  output logic      [VALUE_WIDTH:0] magnitude
);

  localparam int PW = VALUE_WIDTH + 5;

  phase_t                 phase_r, phase_nxt;
  logic                   negative_r, negative_nxt;
  logic [VALUE_WIDTH:0]   mag_r, mag_nxt;
  logic [PW-1:0]          mag_ext, scaled, cap;
  logic [3:0]             digit;
  logic                   is_digit, is_blank, is_sign;

  assign cap      = {4'b0000, 1'b1, {VALUE_WIDTH{1'b0}}};
  assign digit    = 4'(char_code - CHAR_0);
  assign is_digit = char_code inside {[CHAR_0:CHAR_9]};
  assign is_blank = char_code inside {CHAR_SPACE, CHAR_TAB};
  assign is_sign  = char_code inside {CHAR_PLUS, CHAR_MINUS};

  // mag * 10 + digit, saturated at 2^VALUE_WIDTH
  assign mag_ext = {4'b0000, mag_r};
  assign scaled  = (mag_ext << 3) + (mag_ext << 1) + PW'(digit);

  always_comb begin
    phase_nxt    = phase_r;
    negative_nxt = negative_r;
    mag_nxt      = mag_r;
    if (step) begin
      if (char_code == CHAR_NL) begin
        phase_nxt    = PH_BLANK;
        negative_nxt = 1'b0;
        mag_nxt      = '0;
      end else begin
        case (phase_r)
          PH_BLANK: begin
            if (is_sign) begin
              phase_nxt    = PH_DIGITS;
              negative_nxt = (char_code == CHAR_MINUS);
            end else if (is_digit) begin
              phase_nxt = PH_DIGITS;
              mag_nxt   = (scaled > cap) ? cap[VALUE_WIDTH:0] : scaled[VALUE_WIDTH:0];
            end else if (!is_blank) begin
              phase_nxt = PH_DISCARD;
            end
          end
          PH_DIGITS: begin
            if (is_digit) begin
              mag_nxt = (scaled > cap) ? cap[VALUE_WIDTH:0] : scaled[VALUE_WIDTH:0];
            end else begin
              phase_nxt = PH_DISCARD;
            end
          end
          default: begin
            // drop the rest of a bad line
            phase_nxt = PH_DISCARD;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_BLANK;
      negative_r <= 1'b0;
      mag_r      <= '0;
    end else begin
      phase_r    <= phase_nxt;
      negative_r <= negative_nxt;
      mag_r      <= mag_nxt;
    end
  end

  assign ctrl.phase    = phase_r;
  assign ctrl.negative = negative_r;
  assign magnitude     = mag_r;

endmodule

`default_nettype wire

// ===== rtl/core/dilp_result.sv =====
// End-of-line evaluation: sign, range check, status and the result register.
`default_nettype none

module dilp_result
  import dilp_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   load,
  input  wire line_ctrl_t             ctrl,
  input  wire logic [VALUE_WIDTH:0]   magnitude,
  input  wire logic [VALUE_WIDTH-1:0] default_value,
  input  wire logic [VALUE_WIDTH-1:0] min_value,
  input  wire logic [VALUE_WIDTH-1:0] max_value,
  output logic                        can_load,
  dilp_out_if.source                  out_chan
);

  localparam logic [VALUE_WIDTH:0] HALF_P1 =
    {2'b01, {(VALUE_WIDTH-2){1'b0}}, 1'b1};

  logic                          valid_r, valid_nxt;
  logic signed [VALUE_WIDTH-1:0] value_r, value_nxt;
  status_t                       status_r, status_nxt;
  logic        [VALUE_WIDTH:0]   clamped;
  logic signed [VALUE_WIDTH:0]   signed_val, min_x, max_x;
  logic                          out_of_range;

  assign clamped      = (magnitude > HALF_P1) ? HALF_P1 : magnitude;
  assign signed_val   = ctrl.negative ? -$signed(clamped) : $signed(clamped);
  assign min_x        = $signed({min_value[VALUE_WIDTH-1], min_value});
  assign max_x        = $signed({max_value[VALUE_WIDTH-1], max_value});
  assign out_of_range = (signed_val < min_x) || (signed_val > max_x);

  always_comb begin
    case (ctrl.phase)
      PH_BLANK: begin
        value_nxt  = $signed(default_value);
        status_nxt = ST_OK;
      end
      PH_DIGITS: begin
        if (out_of_range) begin
          value_nxt  = '0;
          status_nxt = ST_RANGE;
        end else begin
          value_nxt  = signed_val[VALUE_WIDTH-1:0];
          status_nxt = ST_OK;
        end
      end
      default: begin
        value_nxt  = '0;
        status_nxt = ST_BAD;
      end
    endcase
  end

  assign can_load = !valid_r || out_chan.ready;

  always_comb begin
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      value_r  <= value_nxt;
      status_r <= status_nxt;
    end
  end

  assign out_chan.valid  = valid_r;
  assign out_chan.value  = value_r;
  assign out_chan.status = status_r;

endmodule

`default_nettype wire

// ===== rtl/core/decimal_integer_line_parser.sv =====
// A newline beat is registered in the input stage, then its result in the result register.
// Throughput: one character per cycle; a newline waits in the input stage only
// while the single result register still holds an untaken result.
// Reset (synchronous, rst_n low): line state cleared, input stage and result
// register empty, default 0, min most negative, max most positive.
// Top level of the decimal line parser.
`default_nettype none

module decimal_integer_line_parser
  import dilp_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  dilp_char_if.sink                       in_chan,
  dilp_out_if.source                      out_chan,
  input  wire logic                       cfg_we,
  input  wire logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  wire logic [VALUE_WIDTH-1:0]     cfg_wdata
);

  logic                   s1_v_r, s1_v_nxt;
  logic [7:0]             s1_char_r;
  logic                   accept, advance, can_load, s1_is_nl;
  logic [VALUE_WIDTH-1:0] default_r, min_r, max_r;
  line_ctrl_t             ctrl;
  logic [VALUE_WIDTH:0]   magnitude;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      default_r <= '0;
      min_r     <= {1'b1, {(VALUE_WIDTH-1){1'b0}}};
      max_r     <= {1'b0, {(VALUE_WIDTH-1){1'b1}}};
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DEFAULT: default_r <= cfg_wdata;
        CFG_MIN:     min_r     <= cfg_wdata;
        CFG_MAX:     max_r     <= cfg_wdata;
        default:     ;
      endcase
    end
  end

  // Input stage: a newline advances only when the result register can load
  assign s1_is_nl       = (s1_char_r == CHAR_NL);
  assign advance        = s1_v_r && (!s1_is_nl || can_load);
  assign in_chan.ready  = !s1_v_r || advance;
  assign accept         = in_chan.valid && in_chan.ready;

  always_comb begin
    if (accept) begin
      s1_v_nxt = 1'b1;
    end else if (advance) begin
      s1_v_nxt = 1'b0;
    end else begin
      s1_v_nxt = s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_char_r <= in_chan.char_code;
    end
  end

  dilp_line_state #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_line_state (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (advance),
    .char_code (s1_char_r),
    .ctrl      (ctrl),
    .magnitude (magnitude)
  );

  dilp_result #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_result (
    .clk           (clk),
    .rst_n         (rst_n),
    .load          (advance && s1_is_nl),
    .ctrl          (ctrl),
    .magnitude     (magnitude),
    .default_value (default_r),
    .min_value     (min_r),
    .max_value     (max_r),
    .can_load      (can_load),
    .out_chan      (out_chan)
  );

  // A result appears only after a newline left the input stage
  a_result_from_newline: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_chan.valid) |-> $past(s1_v_r && s1_is_nl))
    else $error("result raised without a newline beat");

  // A rejected line carries a zero value
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.status != ST_OK) |-> (out_chan.value == '0))
    else $error("rejected result with non-zero value");

  // The input stage holds only while an untaken result blocks a newline
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && !advance) |-> (s1_is_nl && out_chan.valid && !out_chan.ready))
    else $error("input stage stalled without a blocked result");

endmodule

`default_nettype wire
